@@ sv/kwm_pkg.sv @@
// Shared constants and types for the key wildcard matcher.
package kwm_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int PAT_IDX_W         = $clog2(MAX_PATTERN_BYTES);
  localparam int LEN_W             = 5;
  localparam int BYTE_W            = 8;
  localparam int CFG_W             = 64;
  localparam int CFG_IDX_W         = 2;

  localparam logic [LEN_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_PATTERN_BYTES);

  // Match mode codes
  typedef enum logic [2:0] {
    MODE_ALL      = 3'd0,
    MODE_EXACT    = 3'd1,
    MODE_PREFIX   = 3'd2,
    MODE_SUFFIX   = 3'd3,
    MODE_CONTAINS = 3'd4
  } mode_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 2'd0,
    REG_PATTERN_HIGH   = 2'd1,
    REG_PATTERN_LENGTH = 2'd2,
    REG_MATCH_MODE     = 2'd3
  } cfg_reg_t;

endpackage

@@ sv/key_wildcard_matcher_unit.sv @@
// Latency: one result beat appears the cycle after the last key byte is taken.
// Throughput: one key byte per cycle unless stalled; the window cells compare in parallel
// with the shift. A finished result sits in an output register, so input is taken while it
// waits provided the result is taken in the same cycle or the register is empty.
// Reset (rst, synchronous): pattern 0, length 1, mode match all, length count and flags
// cleared (window bytes are not reset, only filled bytes are compared), no result pending.
module key_wildcard_matcher_unit
  import kwm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // key byte stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] key_byte
  input  logic                 s_tlast,   // last_byte
  // result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata    // [0] matched, [7:1] zero
);

  // configuration registers
  logic [CFG_W-1:0] pattern_low;
  logic [CFG_W-1:0] pattern_high;
  logic [LEN_W-1:0] pattern_length;
  mode_t            match_mode;

  // per-key state
  logic [LEN_W-1:0] bytes_seen;
  logic             prefix_still_equal;
  logic             found_inside;

  // output register
  logic             out_valid;
  logic             out_matched;

  logic [BYTE_W-1:0] pat [MAX_PATTERN_BYTES];
  logic [BYTE_W-1:0] chain [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hits;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] bytes_seen_next;
  logic             prefix_next;
  logic             long_enough;
  logic             tail_eq;
  logic             found_next;
  logic             matched_next;
  logic             accept;
  logic [BYTE_W-1:0] key_byte;

  assign key_byte = s_tdata[BYTE_W-1:0];
  assign s_tready = !out_valid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low    <= '0;
      pattern_high   <= '0;
      pattern_length <= LEN_W'(1);
      match_mode     <= MODE_ALL;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:    pattern_low    <= cfg_wdata;
        REG_PATTERN_HIGH:   pattern_high   <= cfg_wdata;
        REG_PATTERN_LENGTH: pattern_length <= cfg_wdata[LEN_W-1:0];
        REG_MATCH_MODE:     match_mode     <= mode_t'(cfg_wdata[2:0]);
        default: ;
      endcase
    end
  end

  // unpack pattern bytes
  always_comb begin
    for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
      if (j < 8) begin
        pat[j] = pattern_low[8*j +: 8];
      end else begin
        pat[j] = pattern_high[8*(j-8) +: 8];
      end
    end
  end

  // length clamped to 1..MAX_PATTERN_BYTES
  always_comb begin
    priority if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (pattern_length > LEN_MAX) begin
      eff_len = LEN_MAX;
    end else begin
      eff_len = pattern_length;
    end
  end

  // window chain: cell k holds the k-th newest byte
  for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
    localparam logic [LEN_W-1:0] K = LEN_W'(k);
    logic [BYTE_W-1:0] din;
    logic [LEN_W-1:0]  exp_pos;

    if (k == 0) begin : g_head
      assign din = key_byte;
    end else begin : g_body
      assign din = chain[k-1];
    end

    // newest byte lines up with the final pattern byte
    assign exp_pos = eff_len - LEN_W'(1) - K;

    kwm_cell u_cell (
      .clk      (clk),
      .shift    (accept),
      .din      (din),
      .exp_byte (pat[exp_pos[PAT_IDX_W-1:0]]),
      .active   (K < eff_len),
      .dout     (chain[k]),
      .hit      (hits[k])
    );
  end

  // per-key flags as they stand after this byte
  always_comb begin
    prefix_next = prefix_still_equal;
    if (bytes_seen < eff_len && key_byte != pat[bytes_seen[PAT_IDX_W-1:0]]) begin
      prefix_next = 1'b0;
    end
    bytes_seen_next = (bytes_seen < COUNT_MAX) ? bytes_seen + LEN_W'(1) : bytes_seen;
    long_enough     = bytes_seen_next >= eff_len;
    tail_eq         = long_enough && (&hits);
    found_next      = found_inside || tail_eq;
  end

  // verdict on the last byte
  always_comb begin
    unique case (match_mode)
      MODE_ALL:      matched_next = 1'b1;
      MODE_EXACT:    matched_next = (bytes_seen_next == eff_len) && prefix_next;
      MODE_PREFIX:   matched_next = long_enough && prefix_next;
      MODE_SUFFIX:   matched_next = tail_eq;
      MODE_CONTAINS: matched_next = found_next;
      default:       matched_next = 1'b0;
    endcase
  end

  // per-key state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen         <= '0;
      prefix_still_equal <= 1'b1;
      found_inside       <= 1'b0;
    end else if (accept) begin
      if (s_tlast) begin
        bytes_seen         <= '0;
        prefix_still_equal <= 1'b1;
        found_inside       <= 1'b0;
      end else begin
        bytes_seen         <= bytes_seen_next;
        prefix_still_equal <= prefix_next;
        found_inside       <= found_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && s_tlast) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      out_matched <= matched_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_matched};

endmodule

@@ sv/kwm_cell.sv @@
// One window cell: holds a key byte, passes it on and compares against its pattern byte.
module kwm_cell
  import kwm_pkg::*;
(
  input  logic              clk,
  input  logic              shift,
  input  logic [BYTE_W-1:0] din,
  input  logic [BYTE_W-1:0] exp_byte,
  input  logic              active,
  output logic [BYTE_W-1:0] dout,
  output logic              hit
);

  logic [BYTE_W-1:0] held;

  // byte moves one place along the chain per beat
  always_ff @(posedge clk) begin
    if (shift) begin
      held <= din;
    end
  end

  assign dout = held;

  // compare the byte this cell holds after the shift; unused cells always agree
  assign hit = !active || (din == exp_byte);

endmodule

@@ sv/kwm_checker.sv @@
// Port-level checks for the key wildcard matcher, bound to the top level.
module kwm_checker
  import kwm_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 s_tlast,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [7:0]           m_tdata
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // every last key byte yields a result beat next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("no result after last key byte");

  // a result only appears after a last key byte
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("result without a last key byte");

  // padding bits of the result stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[7:1] == 7'd0)
    else $error("result padding not zero");

endmodule

bind key_wildcard_matcher_unit kwm_checker u_kwm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ sim/key_wildcard_matcher_unit_test.sv @@
`timescale 1ns / 100ps
// Self-checking stream testbench for the key wildcard matcher unit.
module key_wildcard_matcher_unit_test;
  import kwm_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_BYTES = 2000;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata   = '0;   // [7:0] key_byte
  logic                 s_tlast   = 1'b0; // last_byte
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [7:0]           m_tdata;          // [0] matched, [7:1] zero

  key_wildcard_matcher_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Predictor copy of the registers and the per-key state
  logic [63:0] cfg_pat_lo;
  logic [63:0] cfg_pat_hi;
  logic [4:0]  cfg_pat_len;
  logic [2:0]  cfg_mode;
  logic [7:0]  win_bytes [16];
  int          key_len;
  bit          head_ok;
  bit          hit_seen;

  bit          match_q[$];   // expected matched bits, oldest first
  logic [7:0]  key_buf[$];   // key under construction

  int  cycle_count     = 0;
  int  fail_count      = 0;
  int  results_checked = 0;
  int  bytes_sent      = 0;
  int  cfg_writes      = 0;
  bit  src_gaps_on     = 1'b1;
  bit  sink_stalls_on  = 1'b1;
  bit  small_alpha     = 1'b0;
  int  sink_hold_req   = 0;

  // Clock
  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic logic [7:0] pattern_byte(input int j);
    if (j < 8) return cfg_pat_lo[8*j +: 8];
    return cfg_pat_hi[8*(j-8) +: 8];
  endfunction

  // Length 0 counts as 1, anything past the window as the full window
  function automatic int used_length();
    if (cfg_pat_len == 0) return 1;
    if (cfg_pat_len > MAX_PATTERN_BYTES) return MAX_PATTERN_BYTES;
    return int'(cfg_pat_len);
  endfunction

  task automatic clear_key_state();
    int i;
    for (i = 0; i < 16; i++) win_bytes[i] = '0;
    key_len  = 0;
    head_ok  = 1'b1;
    hit_seen = 1'b0;
  endtask

  // Advance the per-key state by one byte; queue the match bit on the last one
  task automatic predict_match(input logic [7:0] b, input logic is_last);
    int i;
    int len;
    bit long_enough;
    bit tail_eq;
    bit m;
    len = used_length();
    if (key_len < len && b != pattern_byte(key_len)) head_ok = 1'b0;
    for (i = 15; i > 0; i--) win_bytes[i] = win_bytes[i-1];
    win_bytes[0] = b;
    if (key_len < COUNT_MAX) key_len++;
    long_enough = key_len >= len;
    tail_eq = long_enough;
    for (i = 0; i < len; i++) begin
      if (win_bytes[len-1-i] != pattern_byte(i)) tail_eq = 1'b0;
    end
    if (tail_eq) hit_seen = 1'b1;
    if (is_last) begin
      case (cfg_mode)
        MODE_ALL:      m = 1'b1;
        MODE_EXACT:    m = (key_len == len) && head_ok;
        MODE_PREFIX:   m = long_enough && head_ok;
        MODE_SUFFIX:   m = tail_eq;
        MODE_CONTAINS: m = hit_seen;
        default:       m = 1'b0;
      endcase
      match_q.push_back(m);
      clear_key_state();
    end
  endtask

  // Mostly no gap, some short, a few long
  function automatic int pick_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] rand_key_byte();
    if (small_alpha) return 8'h40 + 8'($urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  // Offer one beat and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= is_last;
    do @(posedge clk); while (!s_tready);
    predict_match(b, is_last);
    bytes_sent++;
    gap = pick_gap(src_gaps_on);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      s_tdata  <= 8'($urandom);
      s_tlast  <= 1'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_key();
    int i;
    for (i = 0; i < key_buf.size(); i++) send_byte(key_buf[i], i == key_buf.size() - 1);
  endtask

  task automatic idle_source();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Sender pauses until every expected result is back, then lets the block settle
  task automatic wait_drain();
    idle_source();
    while (match_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      REG_PATTERN_LOW:    cfg_pat_lo  = data;
      REG_PATTERN_HIGH:   cfg_pat_hi  = data;
      REG_PATTERN_LENGTH: cfg_pat_len = data[4:0];
      REG_MATCH_MODE:     cfg_mode    = data[2:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  // Short registers sometimes get junk in the unused upper bits
  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [4:0] len, input logic [2:0] mode);
    logic [CFG_W-1:0] w;
    cfg_write(REG_PATTERN_LOW, lo);
    cfg_write(REG_PATTERN_HIGH, hi);
    w = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    w[4:0] = len;
    cfg_write(REG_PATTERN_LENGTH, w);
    w = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    w[2:0] = mode;
    cfg_write(REG_MATCH_MODE, w);
  endtask

  task automatic push_pattern(input int n);
    int i;
    for (i = 0; i < n; i++) key_buf.push_back(pattern_byte(i));
  endtask

  task automatic push_random(input int n);
    int i;
    for (i = 0; i < n; i++) key_buf.push_back(rand_key_byte());
  endtask

  // Result sink: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int n;
    forever begin
      @(negedge clk);
      if (sink_hold_req > 0) begin
        n = sink_hold_req;
        sink_hold_req = 0;
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else if (sink_stalls_on && $urandom_range(0, 3) == 0) begin
        n = pick_gap(1'b1);
        if (n == 0) n = 1;
        m_tready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Result checker
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (match_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, got %02h", $time, m_tdata);
        fail_count++;
      end else begin
        want = {7'b0, match_q.pop_front()};
        if (m_tdata !== want) begin
          $display("%0t: matched mismatch, expected %02h, got %02h", $time, want, m_tdata);
          fail_count++;
        end
        results_checked++;
      end
    end
  end

  // Reset state: match all, length 1, for one-byte and longer keys
  task automatic test_match_all_after_reset();
    key_buf = '{8'h00};
    send_key();
    key_buf = '{8'hFF, 8'h5A, 8'h80};
    send_key();
    wait_drain();
  endtask

  // Pattern "abc" with unused bytes set, through exact, prefix, suffix, contains and an undefined code
  task automatic test_each_mode();
    set_config(64'hFFFF_FFFF_FF63_6261, '1, 5'd3, MODE_EXACT);
    key_buf = '{8'h61, 8'h62, 8'h63};
    send_key();
    // shorter than the pattern
    key_buf = '{8'h61, 8'h62};
    send_key();
    wait_drain();
    cfg_write(REG_MATCH_MODE, 64'(MODE_PREFIX));
    key_buf = '{8'h61, 8'h62, 8'h63, 8'hFF};
    send_key();
    wait_drain();
    cfg_write(REG_MATCH_MODE, 64'(MODE_SUFFIX));
    key_buf = '{8'h00, 8'h61, 8'h62, 8'h63};
    send_key();
    wait_drain();
    cfg_write(REG_MATCH_MODE, 64'(MODE_CONTAINS));
    key_buf = '{8'hFF, 8'h61, 8'h62, 8'h63, 8'h00};
    send_key();
    wait_drain();
    // undefined mode code never matches
    cfg_write(REG_MATCH_MODE, 64'd7);
    key_buf = '{8'h61, 8'h62, 8'h63};
    send_key();
    wait_drain();
  endtask

  // Length zero behaves as one
  task automatic test_zero_length();
    set_config(64'h0000_0000_0000_00FF, '0, 5'd0, MODE_EXACT);
    key_buf = '{8'hFF};
    send_key();
    wait_drain();
  endtask

  // Mode change between bytes of one key
  task automatic test_config_mid_key();
    set_config(64'h0000_0000_0063_6261, '0, 5'd3, MODE_EXACT);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    wait_drain();
    cfg_write(REG_MATCH_MODE, 64'(MODE_PREFIX));
    send_byte(8'h63, 1'b0);
    send_byte(8'hFF, 1'b1);
    wait_drain();
  endtask

  // Long sink hold-off while short keys keep arriving
  task automatic test_output_backpressure();
    int k;
    small_alpha = 1'b1;
    set_config(64'h0000_0000_0000_4140, '0, 5'd2, MODE_CONTAINS);
    src_gaps_on   = 1'b0;
    sink_hold_req = 400;
    for (k = 0; k < 60; k++) begin
      key_buf = {};
      push_random($urandom_range(1, 2));
      send_key();
    end
    wait_drain();
    src_gaps_on = 1'b1;
    small_alpha = 1'b0;
  endtask

  // Mostly keys built around the pattern, the rest noise
  task automatic build_key();
    int len;
    int cut;
    len = used_length();
    key_buf = {};
    case ($urandom_range(0, 9))
      0, 1: push_pattern(len);
      2: begin
        push_pattern(len);
        push_random($urandom_range(1, 6));
      end
      3: begin
        push_random($urandom_range(1, 6));
        push_pattern(len);
      end
      4: begin
        push_random($urandom_range(1, 6));
        push_pattern(len);
        push_random($urandom_range(1, 6));
      end
      5: begin
        push_pattern(len);
        cut = $urandom_range(0, len - 1);
        key_buf[cut] = key_buf[cut] ^ (8'h01 << $urandom_range(0, 7));
        if ($urandom_range(0, 1)) push_random($urandom_range(1, 4));
      end
      6: begin
        if (len > 1) push_pattern($urandom_range(1, len - 1));
        else push_random(1);
      end
      7: begin
        // longer than the window, at times long enough to saturate the length count
        push_random($urandom_range(17, 40));
        if ($urandom_range(0, 1)) push_pattern(len);
      end
      default: push_random($urandom_range(1, 8));
    endcase
  endtask

  task automatic test_random_keys();
    int stop_at;
    int phase_end;
    int r;
    logic [4:0] len;
    logic [2:0] mode;
    logic [63:0] lo;
    logic [63:0] hi;
    int i;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      small_alpha = $urandom_range(0, 2) == 0;
      r = $urandom_range(0, 19);
      if (r < 3) len = 5'd16;
      else if (r < 6) len = 5'd1;
      else if (r < 7) len = 5'd0;
      else if (r < 9) len = 5'($urandom_range(17, 31));
      else len = 5'($urandom_range(1, 16));
      r = $urandom_range(0, 11);
      if (r < 10) mode = 3'(r % 5);
      else mode = 3'($urandom_range(5, 7));
      for (i = 0; i < 8; i++) begin
        lo[8*i +: 8] = rand_key_byte();
        hi[8*i +: 8] = rand_key_byte();
      end
      set_config(lo, hi, len, mode);
      src_gaps_on    = $urandom_range(0, 3) != 0;
      sink_stalls_on = $urandom_range(0, 3) != 0;
      phase_end = bytes_sent + $urandom_range(100, 250);
      while (bytes_sent < phase_end) begin
        build_key();
        send_key();
      end
      wait_drain();
    end
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin
    cfg_pat_lo  = '0;
    cfg_pat_hi  = '0;
    cfg_pat_len = 5'd1;
    cfg_mode    = MODE_ALL;
    clear_key_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_match_all_after_reset();
    test_each_mode();
    test_zero_length();
    test_config_mid_key();
    test_output_backpressure();
    test_random_keys();

    wait_drain();
    repeat (8) @(posedge clk);
    $display("Checked %0d match results from %0d key bytes with %0d register writes",
             results_checked, bytes_sent, cfg_writes);
    $display("Covered all modes, odd lengths and mode codes, mid-key writes and sink hold-off");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
